/* hdl/rectilinear_grid_bilinear_interp_top_assert.svh */
// Assertion macros used by the checker module of the interpolator.
`ifndef RECTILINEAR_GRID_BILINEAR_INTERP_TOP_ASSERT_SVH
`define RECTILINEAR_GRID_BILINEAR_INTERP_TOP_ASSERT_SVH

// An implication that must hold at every clock edge outside reset.
`define RGBI_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An implication whose consequence is checked in the cycle after the antecedent.
`define RGBI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/rgbi_pkg.sv */
package rgbi_pkg;

  localparam logic [1:0] CMD_LOAD_X = 2'd0;
  localparam logic [1:0] CMD_LOAD_Y = 2'd1;
  localparam logic [1:0] CMD_LOAD_Z = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  localparam logic [1:0] LINE_ROW0 = 2'd0;
  localparam logic [1:0] LINE_ROW1 = 2'd1;
  localparam logic [1:0] LINE_COL  = 2'd2;

  localparam logic [2:0] FETCH_LAST = 3'd4;

  localparam logic [6:0] COUNT_RESET = 7'd64;

  typedef struct packed {
    logic       load;
    logic       capture;
    logic       init;
    logic       mid1;
    logic       mid2;
    logic       issue;
    logic       compare;
    logic       fetch;
    logic [2:0] fetch_step;
    logic       line_start;
    logic [1:0] line_sel;
    logic       result_write;
  } rgbi_cmd_t;

  typedef struct packed {
    logic search_done;
    logic zero_width;
    logic line_done;
    logic out_free;
  } rgbi_stat_t;

endpackage

/* hdl/rectilinear_grid_bilinear_interp_top.sv */
// Loads are written from the idle state, and the block stays ready for the next transaction.
// A query passes through set-up (init, and a read of two entries per axis to find its order),
// the binary search of both axes, the fetch of the cell, a check of it, the three linear
// steps in the multiply and bit-serial divide unit, and the write of the result.
// A zero-width cell skips the linear steps. Until the result is written, no transaction is
// accepted. Synchronous active-high reset clears the controller and output valid and sets
// both counts to 64; the coordinate and sample memories keep their contents.
module rectilinear_grid_bilinear_interp_top
  import rgbi_pkg::*;
#(
  parameter int MAX_X = 64,
  parameter int MAX_Y = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [6:0]   cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // col[5:0], row[11:6], load_value[43:12], query_x[75:44], query_y[107:76]
  input  logic [111:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // value[31:0]
  output logic [31:0]  m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser
);

  rgbi_cmd_t          cmd;
  rgbi_stat_t         stat;
  logic signed [31:0] out_value;

  rgbi_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_command (s_axis_tuser),
    .in_ready   (s_axis_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rgbi_dp #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_command    (s_axis_tuser),
    .in_col        (s_axis_tdata[5:0]),
    .in_row        (s_axis_tdata[11:6]),
    .in_load_value (s_axis_tdata[43:12]),
    .in_query_x    (s_axis_tdata[75:44]),
    .in_query_y    (s_axis_tdata[107:76]),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (m_axis_tready),
    .out_valid     (m_axis_tvalid),
    .out_value     (out_value),
    .out_status    (m_axis_tuser)
  );

  assign m_axis_tdata = out_value;

endmodule

/* hdl/rgbi_line.sv */
module rgbi_line
  import rgbi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] x0,
  input  logic signed [31:0] y0,
  input  logic signed [31:0] x1,
  input  logic signed [31:0] y1,
  input  logic signed [31:0] xq,
  output logic               done,
  output logic signed [41:0] res
);

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_MULA = 3'd1;
  localparam logic [2:0] L_MULB = 3'd2;
  localparam logic [2:0] L_DIV  = 3'd3;
  localparam logic [2:0] L_FIN  = 3'd4;
  localparam logic [6:0] DIV_LAST = 7'd65;

  logic [2:0]         state;
  logic [6:0]         cnt;
  logic [32:0]        ady;
  logic [32:0]        adq;
  logic [32:0]        adx;
  logic               neg;
  logic signed [31:0] y0r;
  logic [65:0]        prod;
  logic [32:0]        rem;

  logic signed [32:0] dy;
  logic signed [32:0] dq;
  logic signed [32:0] dx;
  logic [33:0]        rem_sh;
  logic               qbit;
  logic               big;
  logic [40:0]        quo;
  logic signed [41:0] quo_s;

  always_comb begin
    dy = {y1[31], y1} - {y0[31], y0};
    dq = {xq[31], xq} - {x0[31], x0};
    dx = {x1[31], x1} - {x0[31], x0};
    rem_sh = {rem, prod[65]};
    qbit = rem_sh >= {1'b0, adx};
    big = (|prod[65:41]) || (prod[40] && (|prod[39:0]));
    quo = big ? {1'b1, 40'd0} : prod[40:0];
    quo_s = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= L_IDLE;
      cnt <= '0;
    end else begin
      case (state)
        L_IDLE: begin
          if (start) begin
            ady <= dy[32] ? 33'(-dy) : 33'(dy);
            adq <= dq[32] ? 33'(-dq) : 33'(dq);
            adx <= dx[32] ? 33'(-dx) : 33'(dx);
            neg <= dy[32] ^ dq[32] ^ dx[32];
            y0r <= y0;
            state <= L_MULA;
          end
        end
        L_MULA: begin
          prod <= 66'(ady * adq[16:0]);
          state <= L_MULB;
        end
        L_MULB: begin
          prod <= prod + {49'(ady * adq[32:17]), 17'd0};
          rem <= '0;
          cnt <= '0;
          state <= L_DIV;
        end
        L_DIV: begin
          rem <= qbit ? 33'(rem_sh - {1'b0, adx}) : rem_sh[32:0];
          prod <= {prod[64:0], qbit};
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) begin
            state <= L_FIN;
          end
        end
        L_FIN: begin
          res <= {{10{y0r[31]}}, y0r} + quo_s;
          done <= 1'b1;
          state <= L_IDLE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/rgbi_dp.sv */
module rgbi_dp
  import rgbi_pkg::*;
#(
  parameter int MAX_X = 64,
  parameter int MAX_Y = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic [1:0]         in_command,
  input  logic [5:0]         in_col,
  input  logic [5:0]         in_row,
  input  logic signed [31:0] in_load_value,
  input  logic signed [31:0] in_query_x,
  input  logic signed [31:0] in_query_y,
  input  rgbi_cmd_t          cmd,
  output rgbi_stat_t         stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic [1:0]         out_status
);

  localparam int XW  = $clog2(MAX_X);
  localparam int YW  = $clog2(MAX_Y);
  localparam int ZW  = $clog2(MAX_X * MAX_Y);
  localparam int XCW = $clog2(MAX_X + 1);
  localparam int YCW = $clog2(MAX_Y + 1);

  logic [6:0] x_count;
  logic [6:0] y_count;

  logic signed [31:0] xmem [MAX_X];
  logic signed [31:0] ymem [MAX_Y];
  logic signed [31:0] zmem [MAX_X * MAX_Y];
  logic [XW-1:0]      xr_addr;
  logic [YW-1:0]      yr_addr;
  logic [ZW-1:0]      zr_addr;
  logic signed [31:0] xr_data;
  logic signed [31:0] yr_data;
  logic signed [31:0] zr_data;
  logic               x_we;
  logic               y_we;
  logic               z_we;

  logic signed [31:0] qx;
  logic signed [31:0] qy;
  logic [XW-1:0]      lox;
  logic [XW-1:0]      hix;
  logic [XW-1:0]      mx;
  logic [YW-1:0]      loy;
  logic [YW-1:0]      hiy;
  logic [YW-1:0]      my;
  logic               ascx;
  logic               ascy;
  logic               actx;
  logic               acty;
  logic signed [31:0] xm;
  logic signed [31:0] ym;
  logic signed [31:0] xa;
  logic signed [31:0] xb;
  logic signed [31:0] ya;
  logic signed [31:0] yb;
  logic signed [31:0] za0;
  logic signed [31:0] zb0;
  logic signed [31:0] za1;
  logic signed [31:0] zb1;
  logic signed [31:0] r0;
  logic signed [31:0] r1;
  logic signed [31:0] rv;
  logic               sat;

  logic [XCW-1:0]     nx;
  logic [YCW-1:0]     ny;
  logic [XW-1:0]      hx0;
  logic [YW-1:0]      hy0;
  logic               done_x;
  logic               done_y;
  logic [XW-1:0]      mid_x;
  logic [YW-1:0]      mid_y;
  logic               upper_x;
  logic               upper_y;
  logic [ZW-1:0]      zbase0;
  logic [ZW-1:0]      zbase1;

  logic signed [31:0] l_x0;
  logic signed [31:0] l_y0;
  logic signed [31:0] l_x1;
  logic signed [31:0] l_y1;
  logic signed [31:0] l_xq;
  logic               l_done;
  logic signed [41:0] l_res;
  logic               clamp;
  logic signed [31:0] l_sat;

  always_comb begin
    if (x_count < 7'd2) begin
      nx = XCW'(2);
    end else if (int'(x_count) > MAX_X) begin
      nx = XCW'(MAX_X);
    end else begin
      nx = XCW'(x_count);
    end
    if (y_count < 7'd2) begin
      ny = YCW'(2);
    end else if (int'(y_count) > MAX_Y) begin
      ny = YCW'(MAX_Y);
    end else begin
      ny = YCW'(y_count);
    end
    hx0 = XW'(nx - 1'b1);
    hy0 = YW'(ny - 1'b1);
    done_x = {1'b0, hix} <= ({1'b0, lox} + 1'b1);
    done_y = {1'b0, hiy} <= ({1'b0, loy} + 1'b1);
    mid_x = XW'(({1'b0, hix} + {1'b0, lox}) >> 1);
    mid_y = YW'(({1'b0, hiy} + {1'b0, loy}) >> 1);
    upper_x = ascx ? (xr_data > qx) : (xr_data <= qx);
    upper_y = ascy ? (yr_data > qy) : (yr_data <= qy);
    zbase0 = ZW'(lox) * ZW'(MAX_Y);
    zbase1 = zbase0 + ZW'(MAX_Y);
  end

  always_comb begin
    xr_addr = '0;
    yr_addr = '0;
    zr_addr = '0;
    if (cmd.init) begin
      xr_addr = hx0 >> 1;
      yr_addr = hy0 >> 1;
    end else if (cmd.mid1) begin
      xr_addr = mx + 1'b1;
      yr_addr = my + 1'b1;
    end else if (cmd.issue) begin
      xr_addr = mid_x;
      yr_addr = mid_y;
    end else if (cmd.fetch) begin
      case (cmd.fetch_step)
        3'd0: begin
          xr_addr = lox;
          yr_addr = loy;
          zr_addr = zbase0 + ZW'(loy);
        end
        3'd1: begin
          xr_addr = lox + 1'b1;
          yr_addr = loy + 1'b1;
          zr_addr = zbase1 + ZW'(loy);
        end
        3'd2: begin
          zr_addr = zbase0 + ZW'(loy) + 1'b1;
        end
        3'd3: begin
          zr_addr = zbase1 + ZW'(loy) + 1'b1;
        end
        default: begin
          zr_addr = '0;
        end
      endcase
    end
  end

  assign x_we = cmd.load && (in_command == CMD_LOAD_X) && (int'(in_col) < MAX_X);
  assign y_we = cmd.load && (in_command == CMD_LOAD_Y) && (int'(in_row) < MAX_Y);
  assign z_we = cmd.load && (in_command == CMD_LOAD_Z) && (int'(in_col) < MAX_X)
                && (int'(in_row) < MAX_Y);

  always_ff @(posedge clk) begin
    if (x_we) begin
      xmem[XW'(in_col)] <= in_load_value;
    end
    xr_data <= xmem[xr_addr];
  end

  always_ff @(posedge clk) begin
    if (y_we) begin
      ymem[YW'(in_row)] <= in_load_value;
    end
    yr_data <= ymem[yr_addr];
  end

  always_ff @(posedge clk) begin
    if (z_we) begin
      zmem[ZW'(ZW'(in_col) * ZW'(MAX_Y) + ZW'(in_row))] <= in_load_value;
    end
    zr_data <= zmem[zr_addr];
  end

  always_comb begin
    l_x0 = xa;
    l_x1 = xb;
    l_xq = qx;
    l_y0 = za0;
    l_y1 = zb0;
    case (cmd.line_sel)
      LINE_ROW0: begin
        l_y0 = za0;
        l_y1 = zb0;
      end
      LINE_ROW1: begin
        l_y0 = za1;
        l_y1 = zb1;
      end
      LINE_COL: begin
        l_x0 = ya;
        l_x1 = yb;
        l_xq = qy;
        l_y0 = r0;
        l_y1 = r1;
      end
      default: begin
        l_y0 = za0;
      end
    endcase
  end

  rgbi_line u_line (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.line_start),
    .x0    (l_x0),
    .y0    (l_y0),
    .x1    (l_x1),
    .y1    (l_y1),
    .xq    (l_xq),
    .done  (l_done),
    .res   (l_res)
  );

  always_comb begin
    clamp = (l_res[41:31] != {11{1'b0}}) && (l_res[41:31] != {11{1'b1}});
    if (clamp) begin
      l_sat = l_res[41] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      l_sat = l_res[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      qx <= in_query_x;
      qy <= in_query_y;
      sat <= 1'b0;
    end
    if (cmd.init) begin
      lox <= '0;
      hix <= hx0;
      mx <= hx0 >> 1;
      loy <= '0;
      hiy <= hy0;
      my <= hy0 >> 1;
    end
    if (cmd.mid1) begin
      xm <= xr_data;
      ym <= yr_data;
    end
    if (cmd.mid2) begin
      ascx <= xm < xr_data;
      ascy <= ym < yr_data;
    end
    if (cmd.issue) begin
      actx <= !done_x;
      acty <= !done_y;
      mx <= mid_x;
      my <= mid_y;
    end
    if (cmd.compare) begin
      if (actx) begin
        if (upper_x) begin
          hix <= mx;
        end else begin
          lox <= mx;
        end
      end
      if (acty) begin
        if (upper_y) begin
          hiy <= my;
        end else begin
          loy <= my;
        end
      end
    end
    if (cmd.fetch) begin
      case (cmd.fetch_step)
        3'd1: begin
          xa <= xr_data;
          ya <= yr_data;
          za0 <= zr_data;
        end
        3'd2: begin
          xb <= xr_data;
          yb <= yr_data;
          zb0 <= zr_data;
        end
        3'd3: begin
          za1 <= zr_data;
        end
        3'd4: begin
          zb1 <= zr_data;
        end
        default: begin
        end
      endcase
    end
    if (l_done) begin
      case (cmd.line_sel)
        LINE_ROW0: r0 <= l_sat;
        LINE_ROW1: r1 <= l_sat;
        default: rv <= l_sat;
      endcase
      if (clamp) begin
        sat <= 1'b1;
      end
    end
    if (cmd.result_write) begin
      out_value <= stat.zero_width ? 32'sd0 : rv;
      out_status <= stat.zero_width ? STAT_ZERO : (sat ? STAT_SAT : STAT_OK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      x_count <= COUNT_RESET;
      y_count <= COUNT_RESET;
    end else begin
      if (cmd.result_write) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we && !cfg_index) begin
        x_count <= cfg_data;
      end
      if (cfg_we && cfg_index) begin
        y_count <= cfg_data;
      end
    end
  end

  always_comb begin
    stat.search_done = done_x && done_y;
    stat.zero_width = (xa == xb) || (ya == yb);
    stat.line_done = l_done;
    stat.out_free = !out_valid || out_ready;
  end

endmodule

/* hdl/rgbi_ctrl.sv */
module rgbi_ctrl
  import rgbi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  output logic       in_ready,
  input  rgbi_stat_t stat,
  output rgbi_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_MID1  = 4'd2;
  localparam logic [3:0] S_MID2  = 4'd3;
  localparam logic [3:0] S_SRCH  = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_FETCH = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_LS    = 4'd8;
  localparam logic [3:0] S_LW    = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [2:0] fstep;
  logic [2:0] fstep_next;
  logic [1:0] lsel;
  logic [1:0] lsel_next;
  logic       in_fire;

  assign in_ready = state == S_IDLE;
  assign in_fire = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.fetch_step = fstep;
    cmd.line_sel = lsel;
    state_next = state;
    fstep_next = fstep;
    lsel_next = lsel;
    case (state)
      S_IDLE: begin
        cmd.load = in_fire && (in_command != CMD_QUERY);
        cmd.capture = in_fire && (in_command == CMD_QUERY);
        if (cmd.capture) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init = 1'b1;
        state_next = S_MID1;
      end
      S_MID1: begin
        cmd.mid1 = 1'b1;
        state_next = S_MID2;
      end
      S_MID2: begin
        cmd.mid2 = 1'b1;
        state_next = S_SRCH;
      end
      S_SRCH: begin
        if (stat.search_done) begin
          fstep_next = '0;
          state_next = S_FETCH;
        end else begin
          cmd.issue = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_next = S_SRCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (fstep == FETCH_LAST) begin
          state_next = S_CHK;
        end else begin
          fstep_next = fstep + 1'b1;
        end
      end
      S_CHK: begin
        if (stat.zero_width) begin
          state_next = S_DONE;
        end else begin
          lsel_next = LINE_ROW0;
          state_next = S_LS;
        end
      end
      S_LS: begin
        cmd.line_start = 1'b1;
        state_next = S_LW;
      end
      S_LW: begin
        if (stat.line_done) begin
          if (lsel == LINE_COL) begin
            state_next = S_DONE;
          end else begin
            lsel_next = lsel + 1'b1;
            state_next = S_LS;
          end
        end
      end
      S_DONE: begin
        cmd.result_write = stat.out_free;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fstep <= '0;
      lsel <= LINE_ROW0;
    end else begin
      state <= state_next;
      fstep <= fstep_next;
      lsel <= lsel_next;
    end
  end

endmodule

/* hdl/rgbi_checker.sv */
`include "rectilinear_grid_bilinear_interp_top_assert.svh"

module rgbi_checker
  import rgbi_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  `RGBI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
  `RGBI_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  `RGBI_ASSERT_IMP(a_status_code, m_axis_tvalid, m_axis_tuser == STAT_OK || m_axis_tuser == STAT_ZERO || m_axis_tuser == STAT_SAT, "undefined status code")
  `RGBI_ASSERT_IMP(a_zero_value, m_axis_tvalid && m_axis_tuser == STAT_ZERO, m_axis_tdata == 32'd0, "zero-width result is not zero")
  `RGBI_ASSERT_NEXT(a_query_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_QUERY, !s_axis_tready, "transaction accepted during a query")

endmodule

bind rectilinear_grid_bilinear_interp_top rgbi_checker u_rgbi_checker (.*);
